[sv/mmm_pkg.sv]
// shared types and constants for the mdio management master
package mmm_pkg;

    localparam int PREAMBLE_BITS_DEF = 32;
    localparam int DIVIDER_WIDTH_DEF = 16;

    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 16;

    // configuration register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CLOCK_DIVIDER = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ENABLE        = 2'd1;

    localparam logic [15:0] CLOCK_DIVIDER_RST = 16'd255;

    // input item modes
    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_ACC_WR = 2'd1;
    localparam logic [1:0] MODE_ACC_RD = 2'd2;

    // clause 22 frame fields
    localparam logic [1:0] FRAME_START = 2'b01;
    localparam logic [1:0] OP_READ     = 2'b10;
    localparam logic [1:0] OP_WRITE    = 2'b01;
    localparam logic [1:0] TA_WRITE    = 2'b10;
    localparam logic [1:0] TA_READ     = 2'b00;

    typedef struct packed {
        logic [1:0]  mode;
        logic        go;
        logic        write_op;
        logic [4:0]  phy_addr;
        logic [4:0]  reg_addr;
        logic [15:0] write_data;
        logic        mdio_in;
    } t_in_item;

    typedef struct packed {
        logic        busy_res;
        logic        ack;
        logic [15:0] read_data;
        logic        mdc;
        logic        mdio_out;
        logic        mdio_drive;
    } t_out_item;

    typedef struct packed {
        logic [CFG_INDEX_WIDTH-1:0] index;
        logic [CFG_DATA_WIDTH-1:0]  value;
    } t_cfg_item;

endpackage

[sv/mmm_if.sv]
// valid/ready channel interfaces for items, results and configuration writes
interface mmm_in_if import mmm_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mmm_out_if import mmm_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mmm_cfg_if import mmm_pkg::*; ();
    logic      valid;
    logic      ready;
    t_cfg_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[sv/mdio_management_master_unit.sv]
// mdio management master: clause 22 frame engine with one user-access register
//
// Channels: i_in carries one item per transaction (a clock tick, an access
// register write or an access register read); o_out returns exactly one
// result per item with busy, ack, read data and the mdc/mdio pin levels as
// they stand after that item. i_cfg writes clock_divider (index 0) and
// enable (index 1); it is always ready and takes effect on the next item.
// Output: an item's result is on o_out in the cycle after its transaction.
// Throughput: one item per cycle unless o_out stalls; the frame state and the
// result register are both loaded in the accepting cycle, so nothing iterates.
// Stall: o_out has a single output register; while it holds an untaken
// result, i_in stays ready only in the cycle the result is taken, so no
// result is lost or repeated.
// Reset (i_rst_n low, synchronous): no frame runs, mdc low, ack and read
// data zero, clock_divider 255, enable 0, output register empty.
module mdio_management_master_unit
    import mmm_pkg::*;
#(
    parameter int PREAMBLE_BITS = PREAMBLE_BITS_DEF,
    parameter int DIVIDER_WIDTH = DIVIDER_WIDTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    mmm_in_if.sink    i_in,
    mmm_cfg_if.sink   i_cfg,
    mmm_out_if.source o_out
);

    localparam int FRAME_BITS = PREAMBLE_BITS + 32;
    localparam int BPW        = $clog2(FRAME_BITS + 1);

    localparam logic [BPW-1:0] POS_FRAME = BPW'(FRAME_BITS);
    localparam logic [BPW-1:0] POS_PRE   = BPW'(PREAMBLE_BITS);
    localparam logic [BPW-1:0] POS_ACK   = BPW'(PREAMBLE_BITS + 15);
    localparam logic [BPW-1:0] POS_DATA  = BPW'(PREAMBLE_BITS + 16);

    // configuration
    logic [15:0]              r_divider;
    logic                     r_enable;

    // frame state
    logic [DIVIDER_WIDTH-1:0] r_tick, n_tick;
    logic                     r_mdc, n_mdc;
    logic [BPW-1:0]           r_bit_pos, n_bit_pos;
    logic [31:0]              r_shift, n_shift;
    logic                     r_running, n_running;
    logic                     r_is_write, n_is_write;
    logic                     r_ack, n_ack;
    logic [15:0]              r_rdata, n_rdata;

    // result register
    logic                     r_out_valid;
    t_out_item                r_out_data;
    t_out_item                n_out_data;

    logic                     in_accept;
    logic [BPW-1:0]           smp_idx;
    logic [BPW-1:0]           out_idx;
    logic [4:0]               out_k;

    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_accept   = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    assign smp_idx = r_bit_pos - BPW'(1);

    always_comb begin
        n_tick     = r_tick;
        n_mdc      = r_mdc;
        n_bit_pos  = r_bit_pos;
        n_shift    = r_shift;
        n_running  = r_running;
        n_is_write = r_is_write;
        n_ack      = r_ack;
        n_rdata    = r_rdata;
        if (in_accept) begin
            case (i_in.data.mode)
                MODE_TICK: begin
                    if (r_enable) begin
                        if (r_tick >= r_divider[DIVIDER_WIDTH-1:0]) begin
                            n_tick = '0;
                            n_mdc  = !r_mdc;
                            if (!r_mdc) begin
                                // rising mdc: sample the bit launched last
                                if (r_running && r_bit_pos != '0 && !r_is_write) begin
                                    if (smp_idx == POS_ACK) begin
                                        n_ack = !i_in.data.mdio_in;
                                    end else if (smp_idx >= POS_DATA && smp_idx < POS_FRAME) begin
                                        n_rdata = {r_rdata[14:0], i_in.data.mdio_in};
                                    end
                                end
                            end else if (r_running) begin
                                // falling mdc: launch next bit or end the frame
                                if (r_bit_pos >= POS_FRAME) begin
                                    n_running = 1'b0;
                                    n_bit_pos = '0;
                                end else begin
                                    n_bit_pos = r_bit_pos + BPW'(1);
                                end
                            end
                        end else begin
                            n_tick = r_tick + DIVIDER_WIDTH'(1);
                        end
                    end
                end
                MODE_ACC_WR: begin
                    if (i_in.data.go && !r_running) begin
                        n_shift = {FRAME_START,
                                   i_in.data.write_op ? OP_WRITE : OP_READ,
                                   i_in.data.phy_addr, i_in.data.reg_addr,
                                   i_in.data.write_op ? TA_WRITE : TA_READ,
                                   i_in.data.write_op ? i_in.data.write_data : 16'h0000};
                        n_is_write = i_in.data.write_op;
                        n_running  = 1'b1;
                        n_bit_pos  = '0;
                        if (!i_in.data.write_op) begin
                            n_ack   = 1'b0;
                            n_rdata = '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // pin levels from the bit currently launched
    assign out_idx = n_bit_pos - BPW'(1);
    assign out_k   = 5'(out_idx - POS_PRE);

    always_comb begin
        n_out_data.busy_res   = n_running;
        n_out_data.ack        = n_ack;
        n_out_data.read_data  = n_rdata;
        n_out_data.mdc        = n_mdc;
        n_out_data.mdio_out   = 1'b1;
        n_out_data.mdio_drive = 1'b0;
        if (n_running && n_bit_pos != '0) begin
            if (out_idx < POS_PRE) begin
                n_out_data.mdio_drive = 1'b1;
            end else if (!n_is_write && out_k >= 5'd14) begin
                // turnaround and data of a read: the phy drives
                n_out_data.mdio_drive = 1'b0;
            end else begin
                n_out_data.mdio_drive = 1'b1;
                n_out_data.mdio_out   = n_shift[5'd31 - out_k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_divider   <= CLOCK_DIVIDER_RST;
            r_enable    <= 1'b0;
            r_tick      <= '0;
            r_mdc       <= 1'b0;
            r_bit_pos   <= '0;
            r_shift     <= '0;
            r_running   <= 1'b0;
            r_is_write  <= 1'b0;
            r_ack       <= 1'b0;
            r_rdata     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                if (i_cfg.data.index == CFG_CLOCK_DIVIDER) begin
                    r_divider <= i_cfg.data.value;
                end else if (i_cfg.data.index == CFG_ENABLE) begin
                    r_enable <= i_cfg.data.value[0];
                end
            end
            r_tick     <= n_tick;
            r_mdc      <= n_mdc;
            r_bit_pos  <= n_bit_pos;
            r_shift    <= n_shift;
            r_running  <= n_running;
            r_is_write <= n_is_write;
            r_ack      <= n_ack;
            r_rdata    <= n_rdata;
            if (in_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_data <= n_out_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_idle_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_running |-> r_bit_pos == '0)
        else $error("bit position nonzero with no frame running");

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_pos <= POS_FRAME)
        else $error("bit position beyond frame length");

    a_release_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_data.mdio_drive |-> r_out_data.mdio_out)
        else $error("mdio_out low while released");

    a_idle_no_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_data.busy_res |-> !r_out_data.mdio_drive)
        else $error("mdio driven with no frame running");

    a_write_keeps_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_running && r_is_write |=> $stable(r_rdata) && $stable(r_ack))
        else $error("write frame changed read results");
`endif

endmodule
